>>> rtl/assert_macros.svh
// Assertion macros shared by the rasterizer RTL.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define LRCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on every clock edge, reset included
`define LRCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/lrcl_pkg.sv
// Package for the line rasterizer: widths, codes, payload and control structs.
// Used by lrcl_lerp and line_rasterizer_color_lerp_top.
package lrcl_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 4;
  localparam int CLIP_BITS  = 11;
  localparam int CHAN_BITS  = 8;
  localparam int RGBA_BITS  = 4 * CHAN_BITS;
  localparam int PROD_BITS  = DELTA_BITS + CHAN_BITS;
  localparam int QCNT_BITS  = $clog2(CHAN_BITS);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DRAWN   = 2'd0,
    STATUS_CLIPPED = 2'd1,
    STATUS_NO_LINE = 2'd2
  } status_e;

  typedef enum logic {
    CFG_CLIP_MAX_X = 1'b0,
    CFG_CLIP_MAX_Y = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_DIFF,
    ST_LD_SETUP,
    ST_LD_ERR,
    ST_STEP,
    ST_CH_REQ,
    ST_CH_WAIT,
    ST_ADV,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    LS_IDLE,
    LS_MUL,
    LS_DIV,
    LS_OUT
  } lerp_state_e;

  typedef struct packed {
    cmd_e                   command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [RGBA_BITS-1:0]   start_rgba;
    logic [RGBA_BITS-1:0]   end_rgba;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [RGBA_BITS-1:0]   pixel_rgba;
    status_e                status;
    logic                   last;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic [CHAN_BITS-1:0]  a;
    logic [CHAN_BITS-1:0]  b;
    logic [DELTA_BITS-1:0] idx;
    logic [DELTA_BITS-1:0] n;
  } lerp_req_t;

  typedef struct packed {
    logic                 done;
    logic [CHAN_BITS-1:0] value;
  } lerp_rsp_t;

endpackage

>>> rtl/lrcl_lerp.sv
// Shared channel interpolation unit: a + trunc((b - a) * idx / n), n > 0.
// A multiply, then a restoring divide, one quotient bit per cycle.
// Depends on lrcl_pkg.
module lrcl_lerp import lrcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lerp_req_t req_i,
  output lerp_rsp_t rsp_o
);

  lerp_state_e st_q, st_d;

  logic                  neg_q;
  logic [CHAN_BITS-1:0]  a_q;
  logic [CHAN_BITS-1:0]  mag_q;
  logic [DELTA_BITS-1:0] idx_q;
  logic [DELTA_BITS-1:0] n_q;
  logic [PROD_BITS-1:0]  rem_q;
  logic [CHAN_BITS-1:0]  quo_q;
  logic [QCNT_BITS-1:0]  bit_q;

  logic [CHAN_BITS:0]    diff;
  logic [PROD_BITS-1:0]  divisor;
  logic                  fits;

  assign diff    = {1'b0, req_i.b} - {1'b0, req_i.a};
  assign divisor = PROD_BITS'(n_q) << bit_q;
  assign fits    = rem_q >= divisor;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      LS_IDLE: if (req_i.start) st_d = LS_MUL;
      LS_MUL:  st_d = LS_DIV;
      LS_DIV:  if (bit_q == '0) st_d = LS_OUT;
      LS_OUT:  st_d = LS_IDLE;
      default: st_d = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= LS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      LS_IDLE: begin
        if (req_i.start) begin
          a_q   <= req_i.a;
          neg_q <= diff[CHAN_BITS];
          mag_q <= diff[CHAN_BITS] ? CHAN_BITS'(-diff) : diff[CHAN_BITS-1:0];
          idx_q <= req_i.idx;
          n_q   <= req_i.n;
        end
      end
      LS_MUL: begin
        rem_q <= PROD_BITS'(mag_q) * PROD_BITS'(idx_q);
        quo_q <= '0;
        bit_q <= QCNT_BITS'(CHAN_BITS - 1);
      end
      LS_DIV: begin
        if (fits) begin
          rem_q        <= rem_q - divisor;
          quo_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp_o.done  = (st_q == LS_OUT);
  assign rsp_o.value = neg_q ? (a_q - quo_q) : (a_q + quo_q);

endmodule

>>> rtl/line_rasterizer_color_lerp_top.sv
// Top level of the Bresenham line rasterizer with RGBA interpolation.
// Depends on lrcl_pkg, lrcl_lerp and assert_macros.svh.
//
// Requests arrive on in_valid_i/in_ready_o with an in_t payload. A load request
// sets up a new line and gives no result; a step request gives one out_t result
// on out_valid_o/out_ready_i: the next pixel with its color, clip status and
// last flag, or status "no line" when no line is active.
// The block works on one request at a time and holds in_ready_o low meanwhile.
// A load runs through the difference, setup and error states. A step of a line with
// nonzero length runs each of the four channels through the shared interpolation
// unit (request, multiply, divide, result), between the pixel setup and the
// Bresenham update, then loads the output register. A step of a zero-length line
// skips the interpolation; a step with no active line also skips the Bresenham
// update.
// The result sits in an output register; a stalled receiver holds the block
// in its final cycle until the register frees, while the previous result waits.
// Clip limits are written on cfg_we_i/cfg_idx_i/cfg_data_i only while idle by the user; the block does not enforce it.
// Reset clears the line (no active line) and sets the clip limits to 639 x 479.
module line_rasterizer_color_lerp_top import lrcl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  cfg_idx_e             cfg_idx_i,
  input  logic [CLIP_BITS-1:0] cfg_data_i
);

  `include "assert_macros.svh"

  state_e state_q, state_d;

  in_t                          req_q;
  logic signed [DELTA_BITS-1:0] dx_q, dy_q;
  logic                         active_q;
  logic                         y_major_q;
  logic signed [COORD_BITS-1:0] major_pos_q, major_end_q, minor_pos_q;
  logic                         minor_neg_q;
  logic [DELTA_BITS-1:0]        dmajor_q, dminor_q;
  logic signed [ERR_BITS-1:0]   err_q;
  logic [DELTA_BITS-1:0]        step_q;
  logic [RGBA_BITS-1:0]         col_first_q, col_second_q;
  logic [CLIP_BITS-1:0]         clip_x_q, clip_y_q;
  out_t                         pend_q;
  logic [1:0]                   ch_q;
  logic                         out_valid_q;
  out_t                         out_q;

  lerp_req_t lerp_req;
  lerp_rsp_t lerp_rsp;

  logic                         accept;
  logic                         emit;
  logic [DELTA_BITS-1:0]        adx, ady;
  logic                         ymaj, swap, dx_pos, dy_pos;
  logic signed [COORD_BITS-1:0] px, py;
  logic                         clipped, is_last;
  logic signed [ERR_BITS-1:0]   dmaj_ext, dmin_ext;

  assign accept = in_valid_i && in_ready_o;
  assign emit   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // load setup
  assign adx    = dx_q[DELTA_BITS-1] ? DELTA_BITS'(-dx_q) : DELTA_BITS'(dx_q);
  assign ady    = dy_q[DELTA_BITS-1] ? DELTA_BITS'(-dy_q) : DELTA_BITS'(dy_q);
  assign ymaj   = !(ady < adx);
  assign swap   = ymaj ? dy_q[DELTA_BITS-1] : dx_q[DELTA_BITS-1];
  assign dx_pos = !dx_q[DELTA_BITS-1] && (dx_q != '0);
  assign dy_pos = !dy_q[DELTA_BITS-1] && (dy_q != '0);

  // current pixel
  assign px      = y_major_q ? minor_pos_q : major_pos_q;
  assign py      = y_major_q ? major_pos_q : minor_pos_q;
  assign clipped = px[COORD_BITS-1] || py[COORD_BITS-1] ||
                   (32'(px[COORD_BITS-2:0]) > 32'(clip_x_q)) ||
                   (32'(py[COORD_BITS-2:0]) > 32'(clip_y_q));
  assign is_last = !(major_pos_q < major_end_q);

  assign dmaj_ext = $signed(ERR_BITS'(dmajor_q));
  assign dmin_ext = $signed(ERR_BITS'(dminor_q));

  assign lerp_req.start = (state_q == ST_CH_REQ);
  assign lerp_req.a     = col_first_q[{ch_q, 3'b000} +: CHAN_BITS];
  assign lerp_req.b     = col_second_q[{ch_q, 3'b000} +: CHAN_BITS];
  assign lerp_req.idx   = step_q;
  assign lerp_req.n     = dmajor_q;

  lrcl_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.command == CMD_LOAD) ? ST_LD_DIFF : ST_STEP;
        end
      end
      ST_LD_DIFF:  state_d = ST_LD_SETUP;
      ST_LD_SETUP: state_d = ST_LD_ERR;
      ST_LD_ERR:   state_d = ST_IDLE;
      ST_STEP: begin
        if (!active_q) begin
          state_d = ST_EMIT;
        end else if (dmajor_q == '0) begin
          state_d = ST_ADV;
        end else begin
          state_d = ST_CH_REQ;
        end
      end
      ST_CH_REQ: state_d = ST_CH_WAIT;
      ST_CH_WAIT: begin
        if (lerp_rsp.done) begin
          state_d = (ch_q == 2'd3) ? ST_ADV : ST_CH_REQ;
        end
      end
      ST_ADV: state_d = ST_EMIT;
      ST_EMIT: if (emit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      clip_x_q    <= CLIP_BITS'(639);
      clip_y_q    <= CLIP_BITS'(479);
    end else begin
      state_q <= state_d;
      if (state_q == ST_LD_SETUP) begin
        active_q <= 1'b1;
      end else if (state_q == ST_ADV && pend_q.last) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CLIP_MAX_X: clip_x_q <= cfg_data_i;
          CFG_CLIP_MAX_Y: clip_y_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= pend_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_q <= in_data_i;
        end
      end
      ST_LD_DIFF: begin
        dx_q <= DELTA_BITS'(req_q.end_x) - DELTA_BITS'(req_q.start_x);
        dy_q <= DELTA_BITS'(req_q.end_y) - DELTA_BITS'(req_q.start_y);
      end
      ST_LD_SETUP: begin
        y_major_q <= ymaj;
        if (ymaj) begin
          major_pos_q <= swap ? req_q.end_y : req_q.start_y;
          major_end_q <= swap ? req_q.start_y : req_q.end_y;
          minor_pos_q <= swap ? req_q.end_x : req_q.start_x;
          minor_neg_q <= swap ? dx_pos : dx_q[DELTA_BITS-1];
          dmajor_q    <= ady;
          dminor_q    <= adx;
        end else begin
          major_pos_q <= swap ? req_q.end_x : req_q.start_x;
          major_end_q <= swap ? req_q.start_x : req_q.end_x;
          minor_pos_q <= swap ? req_q.end_y : req_q.start_y;
          minor_neg_q <= swap ? dy_pos : dy_q[DELTA_BITS-1];
          dmajor_q    <= adx;
          dminor_q    <= ady;
        end
        col_first_q  <= swap ? req_q.end_rgba : req_q.start_rgba;
        col_second_q <= swap ? req_q.start_rgba : req_q.end_rgba;
        step_q       <= '0;
      end
      ST_LD_ERR: begin
        err_q <= (dmin_ext <<< 1) - dmaj_ext;
      end
      ST_STEP: begin
        ch_q <= '0;
        if (!active_q) begin
          pend_q.pixel_x    <= '0;
          pend_q.pixel_y    <= '0;
          pend_q.pixel_rgba <= '0;
          pend_q.status     <= STATUS_NO_LINE;
          pend_q.last       <= 1'b0;
        end else begin
          pend_q.pixel_x    <= px;
          pend_q.pixel_y    <= py;
          pend_q.pixel_rgba <= col_first_q;
          pend_q.status     <= clipped ? STATUS_CLIPPED : STATUS_DRAWN;
          pend_q.last       <= is_last;
        end
      end
      ST_CH_WAIT: begin
        if (lerp_rsp.done) begin
          pend_q.pixel_rgba[{ch_q, 3'b000} +: CHAN_BITS] <= lerp_rsp.value;
          ch_q <= ch_q + 2'd1;
        end
      end
      ST_ADV: begin
        if (err_q > 0) begin
          minor_pos_q <= minor_neg_q ? (minor_pos_q - 1'b1) : (minor_pos_q + 1'b1);
          err_q       <= err_q + ((dmin_ext - dmaj_ext) <<< 1);
        end else begin
          err_q <= err_q + (dmin_ext <<< 1);
        end
        major_pos_q <= major_pos_q + 1'b1;
        step_q      <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

  `LRCL_ASSERT(a_last_ends_line, (state_q == ST_ADV && pend_q.last) |=> !active_q, "last pixel left line active")
  `LRCL_ASSERT(a_major_in_range, active_q && state_q != ST_LD_ERR |-> (major_pos_q <= major_end_q) && (step_q <= dmajor_q), "major position passed line end")
  `LRCL_ASSERT(a_emit_free_reg, (state_q == ST_EMIT && !out_valid_q) |=> out_valid_q, "result not loaded into free output register")

endmodule
